// ===== hdl/rdts_pkg.sv =====
// rdts_pkg: shared constants for the rpm/dwell triangle sweep core
// register map codes, field widths, output caps and register reset values
// no dependencies
package rdts_pkg;

  // field widths
  localparam int ElapsedW = 16;
  localparam int RpmW     = 14;
  localparam int DwellW   = 9;
  localparam int PeriodW  = 16;
  localparam int LimitsW  = 20;
  localparam int ModeW    = 2;

  // register indexes on the apb port
  localparam logic [2:0] REG_SWEEP_TIME  = 3'd0;
  localparam logic [2:0] REG_RPM_MIN     = 3'd1;
  localparam logic [2:0] REG_RPM_MAX     = 3'd2;
  localparam logic [2:0] REG_BASE_RPM    = 3'd3;
  localparam logic [2:0] REG_DWELL_MODE  = 3'd4;
  localparam logic [2:0] REG_DWELL_SWEEP = 3'd5;
  localparam logic [2:0] REG_DWELL_LIM   = 3'd6;
  localparam logic [2:0] REG_DWELL_FIXED = 3'd7;

  // dwell modes
  localparam logic [ModeW-1:0] MODE_INDEP  = 2'd0;
  localparam logic [ModeW-1:0] MODE_SYNC   = 2'd1;
  localparam logic [ModeW-1:0] MODE_INVERT = 2'd2;
  localparam logic [ModeW-1:0] MODE_FIXED  = 2'd3;

  // limits and caps
  localparam logic [RpmW-1:0]    RPM_CAP        = 14'd16000;
  localparam logic [RpmW-1:0]    RPM_MIN_VALID  = 14'd200;
  localparam logic [RpmW-1:0]    RPM_MIN_DFLT   = 14'd500;
  localparam logic [RpmW:0]      RPM_SPAN_DFLT  = 15'd1000;
  localparam logic [DwellW-1:0]  DWELL_CAP      = 9'd500;
  localparam logic [9:0]         DWELL_MIN_VALID = 10'd20;
  localparam logic [9:0]         DWELL_MIN_DFLT = 10'd100;
  localparam logic [10:0]        DWELL_SPAN_DFLT = 11'd100;
  localparam logic [PeriodW-1:0] PERIOD_MIN     = 16'd10;
  localparam logic [PeriodW-1:0] PERIOD_MAX     = 16'd60000;

  // register reset values
  localparam logic [PeriodW-1:0] RST_SWEEP_TIME  = 16'd1000;
  localparam logic [RpmW-1:0]    RST_RPM_MIN     = 14'd500;
  localparam logic [RpmW-1:0]    RST_RPM_MAX     = 14'd3000;
  localparam logic [RpmW-1:0]    RST_BASE_RPM    = 14'd1000;
  localparam logic [ModeW-1:0]   RST_DWELL_MODE  = MODE_FIXED;
  localparam logic [PeriodW-1:0] RST_DWELL_SWEEP = 16'd1000;
  localparam logic [LimitsW-1:0] RST_DWELL_LIM   = 20'd204900;
  localparam logic [DwellW-1:0]  RST_DWELL_FIXED = 9'd250;

endpackage

// ===== hdl/rpm_dwell_triangle_sweep_core.sv =====
// rpm_dwell_triangle_sweep_core: triangle-wave rpm and dwell sweep generator
// top level with apb register file, sequencer and shared multiplier
// depends on rdts_pkg and rdts_div

// Each input beat carries elapsed_ms. A beat with elapsed_ms of zero goes
// straight to hand-over with the last rpm and dwell values and updated low.
// Otherwise the rpm phase (unsigned, PHASE_FRAC_BITS fraction bits, 1.0 at
// 2^PHASE_FRAC_BITS) moves by floor(elapsed*2^F/T) and bounces at 0 and 1.0,
// where T is the sweep time clamped to 10..60000 ms. The step comes from one
// serial divider producing one quotient bit per clock; in independent dwell
// mode the same divider runs a second time for the dwell phase. One
// 14-bit-by-phase multiplier is then used twice, for the rpm and the dwell
// scaling. in_ready is high only between items; a finished result sits in
// the output register and the next item may be accepted while it waits.
// Registers at byte offsets 4*i: sweep_time_ms, rpm_min_setting,
// rpm_max_setting, base_rpm, dwell_mode, dwell_sweep_time_ms, dwell_limits,
// dwell_fixed. Write them only while idle.
module rpm_dwell_triangle_sweep_core #(
  parameter int PHASE_FRAC_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  // apb configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [4:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  // input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rdts_pkg::ElapsedW-1:0]    elapsed_ms,
  // output channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rdts_pkg::RpmW-1:0]        rpm_out,
  output logic [rdts_pkg::DwellW-1:0]      dwell_out,
  output logic                             updated
);

  localparam int F  = PHASE_FRAC_BITS;
  localparam int PW = F + 1;                       // phase width, holds 1.0
  localparam int QW = rdts_pkg::ElapsedW + F;      // step width
  localparam int MW = PW + rdts_pkg::RpmW;         // product width
  localparam logic [PW-1:0] PHASE_ONE = PW'(1) << F;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV_R = 3'd1;
  localparam logic [2:0] S_DIV_D = 3'd2;
  localparam logic [2:0] S_MUL_R = 3'd3;
  localparam logic [2:0] S_SUM_R = 3'd4;
  localparam logic [2:0] S_SUM_D = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  // configuration registers
  logic [rdts_pkg::PeriodW-1:0] sweep_time_ms;
  logic [rdts_pkg::RpmW-1:0]    rpm_min_setting;
  logic [rdts_pkg::RpmW-1:0]    rpm_max_setting;
  logic [rdts_pkg::RpmW-1:0]    base_rpm;
  logic [rdts_pkg::ModeW-1:0]   dwell_mode;
  logic [rdts_pkg::PeriodW-1:0] dwell_sweep_time_ms;
  logic [rdts_pkg::LimitsW-1:0] dwell_limits;
  logic [rdts_pkg::DwellW-1:0]  dwell_fixed;

  // sweep state
  logic [2:0]    state;
  logic [PW-1:0] sweep_phase;
  logic          sweep_rising;
  logic [PW-1:0] dwell_phase;
  logic          dwell_rising;
  logic [rdts_pkg::RpmW-1:0]   last_rpm;
  logic [rdts_pkg::DwellW-1:0] last_dwell;
  logic          upd_flag;
  logic [rdts_pkg::ElapsedW-1:0] elapsed_q;

  // limits, settled from the registers every cycle
  logic [rdts_pkg::RpmW-1:0] rpm_min_q, rpm_span_q;
  logic [9:0]                dwell_min_q, dwell_max_q;
  logic [rdts_pkg::DwellW-1:0] dwell_span_q;

  logic [MW-1:0] prod;

  // divider hookup
  logic                         div_start;
  logic                         div_done;
  logic [QW-1:0]                div_quot;
  logic [rdts_pkg::PeriodW-1:0] div_divisor;
  logic [rdts_pkg::ElapsedW-1:0] div_elapsed;

  logic cfg_write;
  logic in_beat;
  logic out_free;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign in_ready  = (state == S_IDLE);
  assign in_beat   = in_valid & in_ready;
  assign out_free  = ~out_valid | out_ready;

  function automatic logic [rdts_pkg::PeriodW-1:0] clamp_period(
    input logic [rdts_pkg::PeriodW-1:0] t
  );
    logic [rdts_pkg::PeriodW-1:0] r;
    r = t;
    if (t < rdts_pkg::PERIOD_MIN) r = rdts_pkg::PERIOD_MIN;
    else if (t > rdts_pkg::PERIOD_MAX) r = rdts_pkg::PERIOD_MAX;
    return r;
  endfunction

  // one bounce step of a triangle phase: {rising, phase}
  function automatic logic [PW:0] bounce(
    input logic [PW-1:0] phase,
    input logic          rising,
    input logic [QW-1:0] step
  );
    logic [QW:0]   sum;
    logic [PW:0]   r;
    sum = {1'b0, step} + (QW + 1)'(phase);
    if (rising) begin
      if (sum >= (QW + 1)'(PHASE_ONE)) r = {1'b0, PHASE_ONE};
      else r = {1'b1, sum[PW-1:0]};
    end else begin
      if (step >= QW'(phase)) r = {1'b1, {PW{1'b0}}};
      else r = {1'b0, phase - step[PW-1:0]};
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // apb register file
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_time_ms       <= rdts_pkg::RST_SWEEP_TIME;
      rpm_min_setting     <= rdts_pkg::RST_RPM_MIN;
      rpm_max_setting     <= rdts_pkg::RST_RPM_MAX;
      base_rpm            <= rdts_pkg::RST_BASE_RPM;
      dwell_mode          <= rdts_pkg::RST_DWELL_MODE;
      dwell_sweep_time_ms <= rdts_pkg::RST_DWELL_SWEEP;
      dwell_limits        <= rdts_pkg::RST_DWELL_LIM;
      dwell_fixed         <= rdts_pkg::RST_DWELL_FIXED;
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        rdts_pkg::REG_SWEEP_TIME:  sweep_time_ms       <= pwdata[rdts_pkg::PeriodW-1:0];
        rdts_pkg::REG_RPM_MIN:     rpm_min_setting     <= pwdata[rdts_pkg::RpmW-1:0];
        rdts_pkg::REG_RPM_MAX:     rpm_max_setting     <= pwdata[rdts_pkg::RpmW-1:0];
        rdts_pkg::REG_BASE_RPM:    base_rpm            <= pwdata[rdts_pkg::RpmW-1:0];
        rdts_pkg::REG_DWELL_MODE:  dwell_mode          <= pwdata[rdts_pkg::ModeW-1:0];
        rdts_pkg::REG_DWELL_SWEEP: dwell_sweep_time_ms <= pwdata[rdts_pkg::PeriodW-1:0];
        rdts_pkg::REG_DWELL_LIM:   dwell_limits        <= pwdata[rdts_pkg::LimitsW-1:0];
        rdts_pkg::REG_DWELL_FIXED: dwell_fixed         <= pwdata[rdts_pkg::DwellW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      rdts_pkg::REG_SWEEP_TIME:  prdata = 32'(sweep_time_ms);
      rdts_pkg::REG_RPM_MIN:     prdata = 32'(rpm_min_setting);
      rdts_pkg::REG_RPM_MAX:     prdata = 32'(rpm_max_setting);
      rdts_pkg::REG_BASE_RPM:    prdata = 32'(base_rpm);
      rdts_pkg::REG_DWELL_MODE:  prdata = 32'(dwell_mode);
      rdts_pkg::REG_DWELL_SWEEP: prdata = 32'(dwell_sweep_time_ms);
      rdts_pkg::REG_DWELL_LIM:   prdata = 32'(dwell_limits);
      rdts_pkg::REG_DWELL_FIXED: prdata = 32'(dwell_fixed);
    endcase
  end

  // ---------------------------------------------------------------------
  // effective limits
  // registered every cycle; they are first used only after the divider run that follows a beat
  // ---------------------------------------------------------------------
  logic [rdts_pkg::RpmW-1:0] min_r;
  logic [rdts_pkg::RpmW:0]   max_r;
  logic [9:0]                lo_d, hi_d, min_d;
  logic [10:0]               max_d;

  always_comb begin
    // rpm: minimum below 200 falls back to 500
    min_r = (rpm_min_setting >= rdts_pkg::RPM_MIN_VALID) ? rpm_min_setting
                                                         : rdts_pkg::RPM_MIN_DFLT;
    if (rpm_max_setting > min_r) max_r = {1'b0, rpm_max_setting};
    else if (base_rpm > min_r)   max_r = {1'b0, base_rpm};
    else                         max_r = {1'b0, min_r} + rdts_pkg::RPM_SPAN_DFLT;
    if (max_r > {1'b0, rdts_pkg::RPM_CAP}) max_r = {1'b0, rdts_pkg::RPM_CAP};
    // inverted limits give a zero span
    if (max_r < {1'b0, min_r}) max_r = {1'b0, min_r};

    // dwell limits packed as max:min
    lo_d  = dwell_limits[9:0];
    hi_d  = dwell_limits[19:10];
    min_d = (lo_d >= rdts_pkg::DWELL_MIN_VALID) ? lo_d : rdts_pkg::DWELL_MIN_DFLT;
    max_d = (hi_d > min_d) ? {1'b0, hi_d} : ({1'b0, min_d} + rdts_pkg::DWELL_SPAN_DFLT);
    if (max_d > 11'(rdts_pkg::DWELL_CAP)) max_d = 11'(rdts_pkg::DWELL_CAP);
    if (max_d < {1'b0, min_d}) max_d = {1'b0, min_d};
  end

  always_ff @(posedge clk) begin
    rpm_min_q    <= min_r;
    rpm_span_q   <= rdts_pkg::RpmW'(max_r - {1'b0, min_r});
    dwell_min_q  <= min_d;
    dwell_max_q  <= max_d[9:0];
    dwell_span_q <= rdts_pkg::DwellW'(max_d - {1'b0, min_d});
  end

  // ---------------------------------------------------------------------
  // shared serial divider for the phase steps
  // ---------------------------------------------------------------------
  always_comb begin
    div_start   = 1'b0;
    div_divisor = clamp_period(sweep_time_ms);
    div_elapsed = elapsed_q;
    if (state == S_IDLE) begin
      div_start   = in_beat && (elapsed_ms != '0);
      div_elapsed = elapsed_ms;
    end else if (state == S_DIV_R) begin
      // second run for the independent dwell triangle
      div_start   = div_done && (dwell_mode == rdts_pkg::MODE_INDEP);
      div_divisor = clamp_period(dwell_sweep_time_ms);
    end
  end

  rdts_div #(
    .FRAC_BITS (F)
  ) u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (div_start),
    .elapsed_ms (div_elapsed),
    .divisor    (div_divisor),
    .done       (div_done),
    .quotient   (div_quot)
  );

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  logic [PW:0]   sweep_bounce, dwell_bounce;
  logic [PW-1:0] dwell_src;
  logic [rdts_pkg::RpmW-1:0]   scaled;
  logic [rdts_pkg::RpmW:0]     rpm_sum;
  logic [10:0]                 dw_sum;

  assign sweep_bounce = bounce(sweep_phase, sweep_rising, div_quot);
  assign dwell_bounce = bounce(dwell_phase, dwell_rising, div_quot);
  // dwell follows its own phase only in independent mode
  assign dwell_src    = (dwell_mode == rdts_pkg::MODE_INDEP) ? dwell_phase : sweep_phase;
  assign scaled       = prod[F+rdts_pkg::RpmW-1:F];
  assign rpm_sum      = {1'b0, rpm_min_q} + {1'b0, scaled};

  always_comb begin
    unique case (dwell_mode)
      rdts_pkg::MODE_INDEP,
      rdts_pkg::MODE_SYNC:   dw_sum = {1'b0, dwell_min_q} + 11'(scaled);
      rdts_pkg::MODE_INVERT: dw_sum = {1'b0, dwell_max_q} - 11'(scaled);
      rdts_pkg::MODE_FIXED:  dw_sum = 11'(dwell_fixed);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sweep_phase  <= '0;
      sweep_rising <= 1'b1;
      dwell_phase  <= '0;
      dwell_rising <= 1'b1;
      last_rpm     <= '0;
      last_dwell   <= '0;
      upd_flag     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // a taken beat clears valid unless a new one is handed over now
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_beat) begin
            upd_flag <= 1'b0;
            state    <= (elapsed_ms == '0) ? S_DONE : S_DIV_R;
          end
        end
        S_DIV_R: begin
          if (div_done) begin
            sweep_rising <= sweep_bounce[PW];
            sweep_phase  <= sweep_bounce[PW-1:0];
            state <= (dwell_mode == rdts_pkg::MODE_INDEP) ? S_DIV_D : S_MUL_R;
          end
        end
        S_DIV_D: begin
          if (div_done) begin
            dwell_rising <= dwell_bounce[PW];
            dwell_phase  <= dwell_bounce[PW-1:0];
            state        <= S_MUL_R;
          end
        end
        S_MUL_R: state <= S_SUM_R;
        S_SUM_R: begin
          last_rpm <= (rpm_sum > {1'b0, rdts_pkg::RPM_CAP}) ? rdts_pkg::RPM_CAP
                                                            : rpm_sum[rdts_pkg::RpmW-1:0];
          state    <= S_SUM_D;
        end
        S_SUM_D: begin
          last_dwell <= (dw_sum > 11'(rdts_pkg::DWELL_CAP)) ? rdts_pkg::DWELL_CAP
                                                            : dw_sum[rdts_pkg::DwellW-1:0];
          upd_flag   <= 1'b1;
          state      <= S_DONE;
        end
        S_DONE: begin
          // hand over once the output register is free
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // elapsed time held for the second divider run
  always_ff @(posedge clk) begin
    if (in_beat) elapsed_q <= elapsed_ms;
  end

  // shared multiplier, registered product
  always_ff @(posedge clk) begin
    if (state == S_MUL_R) prod <= MW'(sweep_phase * rpm_span_q);
    else if (state == S_SUM_R) prod <= MW'(dwell_src * rdts_pkg::RpmW'(dwell_span_q));
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      rpm_out   <= last_rpm;
      dwell_out <= last_dwell;
      updated   <= upd_flag;
    end
  end

endmodule

// ===== hdl/rdts_div.sv =====
// rdts_div: restoring serial divider, one quotient bit per cycle
// computes (elapsed << FRAC_BITS) / divisor; uses rdts_pkg widths
module rdts_div #(
  parameter int FRAC_BITS = 24
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic [rdts_pkg::ElapsedW-1:0]          elapsed_ms,
  input  logic [rdts_pkg::PeriodW-1:0]           divisor,
  output logic                                   done,
  output logic [rdts_pkg::ElapsedW+FRAC_BITS-1:0] quotient
);

  localparam int QW = rdts_pkg::ElapsedW + FRAC_BITS;
  localparam int CW = $clog2(QW + 1);
  localparam int RW = rdts_pkg::PeriodW + 1;

  logic          busy;
  logic [CW-1:0] count;
  logic [RW-1:0] rem;
  logic [QW-1:0] quot;
  logic [rdts_pkg::PeriodW-1:0] div_q;
  logic [RW-1:0] rem_shift;
  logic          fits;

  // remainder stays below the divisor, so its top bit is always clear
  assign rem_shift = {rem[RW-2:0], quot[QW-1]};
  assign fits      = rem_shift >= {1'b0, div_q};
  assign quotient  = quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(QW);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot  <= {elapsed_ms, {FRAC_BITS{1'b0}}};
      rem   <= '0;
      div_q <= divisor;
    end else if (busy) begin
      rem  <= fits ? (rem_shift - {1'b0, div_q}) : rem_shift;
      quot <= {quot[QW-2:0], fits};
    end
  end

endmodule

// ===== hdl/rdts_checker.sv =====
// rdts_checker: port-level assertions for the sweep core, with its bind
// depends on rdts_pkg and rpm_dwell_triangle_sweep_core
module rdts_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rdts_pkg::RpmW-1:0]     rpm_out,
  input logic [rdts_pkg::DwellW-1:0]   dwell_out
);

  // a result beat is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  // rpm never exceeds its cap
  a_rpm_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rpm_out <= rdts_pkg::RPM_CAP)
    else $error("rpm_out above cap");

  // dwell never exceeds its cap
  a_dwell_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> dwell_out <= rdts_pkg::DWELL_CAP)
    else $error("dwell_out above cap");

  // one item at a time: busy right after an input beat
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

endmodule

bind rpm_dwell_triangle_sweep_core rdts_checker u_rdts_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .rpm_out   (rpm_out),
  .dwell_out (dwell_out)
);
